### rtl/crc8_frame_receiver_macros.svh
// Assertion macros for the CRC-8 frame receiver.
// Used by rtl/crc8_frame_receiver.sv; assumes signals clk and rst_n in scope.
`ifndef CRC8_FRAME_RECEIVER_MACROS_SVH
`define CRC8_FRAME_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
`define CRCFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc8_frame_receiver: assertion failed");
`define CRCFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc8_frame_receiver: assertion failed");
`else
`define CRCFR_ASSERT_IMP(lbl, ante, cons)
`define CRCFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/crcfr_pkg.sv
// Shared types, codes and the CRC-8 byte function for the frame receiver.
// No dependencies.
package crcfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 4;
  localparam int ERR_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_CFG_W = 5;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam logic [STATUS_W-1:0] STATUS_WAIT = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd2;

  localparam byte_t START_BYTE_RST = 8'hA5;
  localparam byte_t CRC_INIT_RST   = 8'h00;
  localparam logic [LEN_CFG_W-1:0] PAYLOAD_LEN_RST = 5'd12;

  localparam byte_t CRC_POLY = 8'h07;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CTL_ACCEPT = 2'd0,
    CTL_READ   = 2'd1,
    CTL_EMIT   = 2'd2
  } ctl_t;

  function automatic byte_t crc8_byte(input byte_t crc, input byte_t data);
    byte_t v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### rtl/crc8_frame_receiver.sv
// CRC-8 framed packet receiver: start-byte detection, payload store, CRC check.
// Depends on crcfr_pkg, crcfr_payload_ram and crc8_frame_receiver_macros.svh.
//
// Usage: link bytes enter on in_rx_byte with in_valid/in_ready. Every input
// transaction yields results on the out_ channel (valid/ready), the final one
// marked by out_last. Bytes outside a frame, and payload bytes, yield one
// waiting result. The CRC byte yields either one error result (counter bumped)
// or the stored payload replayed, one result per stored byte.
// Configuration: cfg_index/cfg_data with cfg_valid/cfg_ready (always ready);
// write only while idle. Index 0 start byte, 1 CRC init, 2 payload length.
// Results are registered: a waiting or error result is valid in the cycle
// after its input transaction; after a good CRC byte the first payload result
// follows a read state, the registered memory read and an emit state.
// Throughput: one input byte per cycle while the output side takes results;
// a good frame replay does a memory read, then an output register load, per byte.
// Input is held off (in_ready low) during replay and while the output
// register holds a result the receiver has not taken.
// Reset: synchronous, clears frame state and the error count, reloads
// configuration defaults; no clearing pass of the payload store is needed.
`include "crc8_frame_receiver_macros.svh"
module crc8_frame_receiver
  import crcfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [IDX_W-1:0]     out_byte_index,
  output logic                 out_last,
  output logic [ERR_W-1:0]     out_error_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
  localparam int LEN_W  = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;

  ctl_t ctl_r, ctl_nxt;
  phase_t phase_r, phase_nxt;
  byte_t crc_r, crc_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [ERR_W-1:0] mismatch_r, mismatch_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;

  byte_t start_byte_r, crc_init_r;
  logic [LEN_CFG_W-1:0] len_r;

  logic out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  byte_t out_payload_r, out_payload_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic out_last_r, out_last_nxt;
  logic [ERR_W-1:0] out_err_r, out_err_nxt;

  logic out_free, in_acc, out_load;
  logic [LEN_W-1:0] len_ext, eff_len;
  logic [CNT_W-1:0] fill_inc;
  logic rd_last;

  logic ram_we, ram_re;
  byte_t ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      crc_init_r   <= CRC_INIT_RST;
      len_r        <= PAYLOAD_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BYTE:  start_byte_r <= cfg_data;
        CFG_CRC_INIT:    crc_init_r <= cfg_data;
        CFG_PAYLOAD_LEN: len_r <= cfg_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (ctl_r == CTL_ACCEPT) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign len_ext  = LEN_W'(len_r);
  assign eff_len  = (len_ext == '0) ? LEN_W'(1) :
                    (len_ext > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : len_ext;
  assign fill_inc = fill_r + CNT_W'(1);
  assign rd_last  = (CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_r;

  always_comb begin
    ctl_nxt         = ctl_r;
    phase_nxt       = phase_r;
    crc_nxt         = crc_r;
    fill_nxt        = fill_r;
    mismatch_nxt    = mismatch_r;
    rd_idx_nxt      = rd_idx_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    out_load        = 1'b0;
    out_status_nxt  = STATUS_WAIT;
    out_payload_nxt = '0;
    out_index_nxt   = '0;
    out_last_nxt    = 1'b1;
    unique case (ctl_r)
      CTL_ACCEPT: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (phase_r)
            PH_RECV: begin
              if (fill_r < CNT_W'(PAYLOAD_MAX)) begin
                ram_we   = 1'b1;
                fill_nxt = fill_inc;
              end
              crc_nxt = crc8_byte(crc_r, in_rx_byte);
              if (LEN_W'(fill_nxt) >= eff_len) begin
                phase_nxt = PH_CRC;
              end
            end
            PH_CRC: begin
              phase_nxt = PH_IDLE;
              if (in_rx_byte == crc_r) begin
                if (fill_r != '0) begin
                  out_load   = 1'b0;
                  rd_idx_nxt = '0;
                  ctl_nxt    = CTL_READ;
                end
              end else begin
                if (mismatch_r != '1) begin
                  mismatch_nxt = mismatch_r + ERR_W'(1);
                end
                out_status_nxt = STATUS_ERR;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              if (in_rx_byte == start_byte_r) begin
                crc_nxt   = crc8_byte(crc_init_r, in_rx_byte);
                fill_nxt  = '0;
                phase_nxt = PH_RECV;
              end
            end
          endcase
        end
      end
      CTL_READ: begin
        ram_re  = 1'b1;
        ctl_nxt = CTL_EMIT;
      end
      CTL_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_nxt  = STATUS_GOOD;
          out_payload_nxt = ram_rdata;
          out_index_nxt   = IDX_W'(rd_idx_r);
          out_last_nxt    = rd_last;
          if (rd_last) begin
            ctl_nxt = CTL_ACCEPT;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            ctl_nxt    = CTL_READ;
          end
        end
      end
      default: ctl_nxt = CTL_ACCEPT;
    endcase
    out_err_nxt   = mismatch_nxt;
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CTL_ACCEPT;
      phase_r     <= PH_IDLE;
      crc_r       <= '0;
      fill_r      <= '0;
      mismatch_r  <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      fill_r      <= fill_nxt;
      mismatch_r  <= mismatch_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= out_status_nxt;
      out_payload_r <= out_payload_nxt;
      out_index_r   <= out_index_nxt;
      out_last_r    <= out_last_nxt;
      out_err_r     <= out_err_nxt;
    end
  end

  crcfr_payload_ram #(
    .DEPTH  (PAYLOAD_MAX),
    .ADDR_W (ADDR_W)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_payload_byte = out_payload_r;
  assign out_byte_index   = out_index_r;
  assign out_last         = out_last_r;
  assign out_error_total  = out_err_r;

  `CRCFR_ASSERT_NXT(a_err_monotonic, 1'b1, mismatch_r >= $past(mismatch_r))
  `CRCFR_ASSERT_IMP(a_recv_room, phase_r == PH_RECV, fill_r < CNT_W'(PAYLOAD_MAX))
  `CRCFR_ASSERT_IMP(a_replay_in_range, ctl_r != CTL_ACCEPT, CNT_W'(rd_idx_r) < fill_r)
  `CRCFR_ASSERT_IMP(a_no_write_in_replay, ctl_r != CTL_ACCEPT, !ram_we)

endmodule

### rtl/crcfr_payload_ram.sv
// Payload store: one write port, one read port with registered read data.
// Depends on crcfr_pkg.
module crcfr_payload_ram
  import crcfr_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  byte_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output byte_t             rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
